// ----- rtl/core/lrupr_pkg.sv -----
`default_nettype none
package lrupr_pkg;

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd4;

    localparam int FAULT_W = 32;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Outcome of one lookup in the recency list.
    typedef struct packed {
        logic hit;
        logic evict;
    } t_lookup;

endpackage
`default_nettype wire

// ----- rtl/core/lrupr_frame_list.sv -----
`default_nettype none
module lrupr_frame_list #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_step,
    input  wire [PAGE_BITS-1:0]        i_page,
    input  wire [lrupr_pkg::CFG_W-1:0] i_frames_in_use,
    output lrupr_pkg::t_lookup         o_lookup,
    output logic [PAGE_BITS-1:0]       o_evicted_page
);
    import lrupr_pkg::*;

    localparam int CW = $clog2(FRAMES + 1);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    // Position 0 holds the least recently used page.
    logic [FRAMES*PAGE_BITS-1:0] r_list;
    logic [FRAMES*PAGE_BITS-1:0] n_list;
    logic [FRAMES*PAGE_BITS-1:0] w_up;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;

    logic [LW-1:0]     w_limit;
    logic [LW-1:0]     w_cfg_ext;
    logic [FRAMES-1:0] w_match;
    logic [IW-1:0]     w_pos;
    logic              w_hit;
    logic              w_evict;
    logic [CW-1:0]     w_shift_from;
    logic [CW-1:0]     w_write_pos;

    always_comb begin
        w_cfg_ext = LW'(i_frames_in_use);
        if (i_frames_in_use == '0) begin
            w_limit = LW'(1);
        end else if (w_cfg_ext > LW'(FRAMES)) begin
            w_limit = LW'(FRAMES);
        end else begin
            w_limit = w_cfg_ext;
        end
    end

    // Resident pages are always distinct, so at most one entry matches.
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < FRAMES; k++) begin
            w_match[k] = (CW'(k) < r_count) && (r_list[k*PAGE_BITS +: PAGE_BITS] == i_page);
            if (w_match[k]) begin
                w_pos = w_pos | IW'(k);
            end
        end
        w_hit = |w_match;
    end

    assign w_evict = !w_hit && (LW'(r_count) >= w_limit) && (r_count != '0);
    assign w_up    = r_list >> PAGE_BITS;

    // Entries from the shift point up to the write point move one place toward
    // the old end; the referenced page lands at the write point.
    always_comb begin
        if (w_hit) begin
            w_shift_from = CW'(w_pos);
        end else if (w_evict) begin
            w_shift_from = '0;
        end else begin
            w_shift_from = CW'(FRAMES);
        end
        w_write_pos = (w_hit || w_evict) ? (r_count - CW'(1)) : r_count;
        n_count     = (w_hit || w_evict) ? r_count : (r_count + CW'(1));
        for (int k = 0; k < FRAMES; k++) begin
            if (CW'(k) == w_write_pos) begin
                n_list[k*PAGE_BITS +: PAGE_BITS] = i_page;
            end else if (CW'(k) >= w_shift_from && CW'(k) < w_write_pos) begin
                n_list[k*PAGE_BITS +: PAGE_BITS] = w_up[k*PAGE_BITS +: PAGE_BITS];
            end else begin
                n_list[k*PAGE_BITS +: PAGE_BITS] = r_list[k*PAGE_BITS +: PAGE_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_list <= n_list;
        end
    end

    assign o_lookup.hit   = w_hit;
    assign o_lookup.evict = w_evict;
    assign o_evicted_page = w_evict ? r_list[PAGE_BITS-1:0] : '0;

endmodule
`default_nettype wire

// ----- rtl/core/lrupr_fault_counter.sv -----
`default_nettype none
module lrupr_fault_counter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  wire                          i_fault,
    output logic [lrupr_pkg::FAULT_W-1:0] o_total_next
);
    import lrupr_pkg::*;

    logic [FAULT_W-1:0] r_total;
    logic [FAULT_W-1:0] n_total;

    always_comb begin
        if (i_fault && r_total != FAULT_MAX) begin
            n_total = r_total + FAULT_W'(1);
        end else begin
            n_total = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_step) begin
            r_total <= n_total;
        end
    end

    assign o_total_next = n_total;

endmodule
`default_nettype wire

// ----- rtl/core/lru_page_replacement_core.sv -----
`default_nettype none
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_page_number
// out     | output    | o_out_valid / i_out_stall | o_page_fault, o_evict_valid,
//         |           |                           | o_evicted_page, o_fault_total
// cfg     | input     | i_cfg_we                  | i_cfg_wdata (frames in use)
//
// One reference per cycle while the output is not stalled: an item is held in the input
// register, and the list lookup, list shift and fault count update happen as it moves
// to the result register, which drives the outputs until the item transfers out.
// Reset empties the frame list, clears the fault count and sets the frame limit to 4.
// A stall on the output holds the result register and then the input register.
module lru_page_replacement_core #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [PAGE_BITS-1:0]                 i_page_number,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_page_fault,
    output logic                                o_evict_valid,
    output logic [PAGE_BITS-1:0]                o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]       o_fault_total,
    input  wire                                 i_cfg_we,
    input  wire [lrupr_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import lrupr_pkg::*;

    logic [CFG_W-1:0]     r_frames_in_use;
    logic                 r_in_valid;
    logic [PAGE_BITS-1:0] r_in_page;
    logic                 r_out_valid;
    logic                 w_out_free;
    logic                 w_step;
    t_lookup              w_lookup;
    logic [PAGE_BITS-1:0] w_evicted_page;
    logic [FAULT_W-1:0]   w_total_next;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_IN_USE_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_page <= i_page_number;
        end
    end

    lrupr_frame_list #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_frame_list (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_page          (r_in_page),
        .i_frames_in_use (r_frames_in_use),
        .o_lookup        (w_lookup),
        .o_evicted_page  (w_evicted_page)
    );

    lrupr_fault_counter u_fault_counter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_fault      (!w_lookup.hit),
        .o_total_next (w_total_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            o_page_fault   <= !w_lookup.hit;
            o_evict_valid  <= w_lookup.evict;
            o_evicted_page <= w_evicted_page;
            o_fault_total  <= w_total_next;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire
